>>> hw/rtl/brr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded random rejection package
// Widths, register indexes and shared types for the bounded random mapper.
// ----------------------------------------------------------------------------
package brr_pkg;

   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int CSR_IDX_W = 1;
   localparam int DIV_CNT_W = $clog2(WORD_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_LOW  = 1'b0,
      CSR_RANGE_HIGH = 1'b1
   } csr_reg_type;

endpackage

>>> hw/rtl/brr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded random rejection channel interfaces
// Valid/ready channels for entropy words in and bounded values out.
// ----------------------------------------------------------------------------
interface brr_req_if;
   logic                      valid;
   logic                      ready;
   logic [brr_pkg::WORD_W-1:0] entropy_word;

   modport source (output valid, output entropy_word, input ready);
   modport sink   (input valid, input entropy_word, output ready);
endinterface

interface brr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [brr_pkg::WORD_W-1:0] bounded_value;

   modport source (output valid, output bounded_value, input ready);
   modport sink   (input valid, input bounded_value, output ready);
endinterface

>>> hw/rtl/bounded_random_rejection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded random rejection
// Maps raw 32-bit random words without bias into [lower, upper).
// ----------------------------------------------------------------------------
// The block takes one entropy word per cycle unless the result side stalls
// or the threshold divider is busy, and either presents a bounded value or
// drops the word as rejected; nothing is returned for a rejected word. The
// three stages are an input register, a 32 x 32 bit multiply by the range,
// and the rejection compare with the add of the lower bound. Every register
// write restarts the rejection threshold calculation, (2^32 - range) mod
// range, on a shift-and-subtract divider that resolves one bit per cycle;
// while it runs req_chan.ready stays low. With the lower bound at or above
// the upper bound every word yields the lower bound.
// ----------------------------------------------------------------------------
module bounded_random_rejection (
   input  logic                          clock,
   input  logic                          reset,
   brr_req_if.sink                       req_chan,
   brr_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [brr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [brr_pkg::WORD_W-1:0]    csr_wdata
);

   localparam int W = brr_pkg::WORD_W;
   localparam logic [brr_pkg::DIV_CNT_W-1:0] DIV_LAST = brr_pkg::DIV_CNT_W'(W - 1);

   // Configuration registers and derived values
   logic [W-1:0] lower_ff, lower_in;
   logic [W-1:0] upper_ff, upper_in;
   logic [W-1:0] range_ff, range_in;
   logic         empty_ff, empty_in;

   // Threshold divider
   logic                          div_load_ff, div_load_in;
   logic                          div_busy_ff, div_busy_in;
   logic [brr_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [W-1:0]                  div_num_ff, div_num_in;
   logic [W-1:0]                  rem_ff, rem_in;
   logic [W:0]                    rem_shift;
   logic [W:0]                    rem_sub;
   logic [W-1:0]                  rem_step;

   // Pipeline
   logic                       s1_valid_ff, s1_valid_in;
   logic [W-1:0]               s1_word_ff, s1_word_in;
   logic                       s2_valid_ff, s2_valid_in;
   logic [brr_pkg::PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic                       s3_valid_ff, s3_valid_in;
   logic [W-1:0]               s3_value_ff, s3_value_in;
   logic                       s1_ready, s2_ready, s3_ready;
   logic                       req_fire;
   logic                       keep;
   logic [W-1:0]               prod_low, prod_high;

   // ---------------------------------------------------------------- config
   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (csr_we) begin
         unique case (brr_pkg::csr_reg_type'(csr_index))
            brr_pkg::CSR_RANGE_LOW:  lower_in = csr_wdata;
            brr_pkg::CSR_RANGE_HIGH: upper_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   // --------------------------------------------------------------- divider
   // Restoring division, one quotient bit per cycle; only the remainder is kept.
   always_comb begin
      rem_shift = {rem_ff, div_num_ff[W-1]};
      rem_sub   = rem_shift - {1'b0, range_ff};
      rem_step  = rem_sub[W] ? rem_shift[W-1:0] : rem_sub[W-1:0];
   end

   always_comb begin
      div_load_in = csr_we;
      div_busy_in = div_busy_ff;
      range_in    = range_ff;
      empty_in    = empty_ff;
      div_num_in  = div_num_ff;
      rem_in      = rem_ff;
      div_cnt_in  = div_cnt_ff;
      if (csr_we) begin
         div_busy_in = 1'b1;
      end else if (div_busy_ff && !div_load_ff && div_cnt_ff == DIV_LAST) begin
         div_busy_in = 1'b0;
      end
      if (div_load_ff) begin
         // The dividend 2^32 - range is lower - upper taken modulo 2^32.
         range_in   = upper_ff - lower_ff;
         empty_in   = lower_ff >= upper_ff;
         div_num_in = lower_ff - upper_ff;
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (div_busy_ff) begin
         div_num_in = {div_num_ff[W-2:0], 1'b0};
         rem_in     = rem_step;
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_load_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         empty_ff    <= 1'b1;
      end else begin
         div_load_ff <= div_load_in;
         div_busy_ff <= div_busy_in;
         empty_ff    <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      range_ff   <= range_in;
      div_num_ff <= div_num_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
   end

   // -------------------------------------------------------------- pipeline
   assign s3_ready       = !s3_valid_ff || rsp_chan.ready;
   assign s2_ready       = !s2_valid_ff || s3_ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready && !div_busy_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign prod_low  = s2_prod_ff[W-1:0];
   assign prod_high = s2_prod_ff[brr_pkg::PROD_W-1:W];
   // The threshold is always below the range, so one compare decides.
   assign keep      = empty_ff || (prod_low >= rem_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      s2_valid_in = s2_valid_ff;
      s2_prod_in  = s2_prod_ff;
      s3_valid_in = s3_valid_ff;
      s3_value_in = s3_value_ff;
      if (s1_ready) begin
         s1_valid_in = req_fire;
         s1_word_in  = req_chan.entropy_word;
      end
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         s2_prod_in  = brr_pkg::PROD_W'(s1_word_ff) * brr_pkg::PROD_W'(range_ff);
      end
      if (s3_ready) begin
         // A rejected word simply leaves a bubble behind.
         s3_valid_in = s2_valid_ff && keep;
         s3_value_in = empty_ff ? lower_ff : prod_high + lower_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff  <= s1_word_in;
      s2_prod_ff  <= s2_prod_in;
      s3_value_ff <= s3_value_in;
   end

   assign rsp_chan.valid         = s3_valid_ff;
   assign rsp_chan.bounded_value = s3_value_ff;

endmodule

>>> hw/rtl/brr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded random rejection checker
// Port-level assertions, attached to bounded_random_rejection by a bind statement.
// ----------------------------------------------------------------------------
module brr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [brr_pkg::WORD_W-1:0] rsp_value,
   input logic                       csr_we
);

   // A result that is not taken stays, unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result item dropped or changed while stalled");

   // A register write starts the threshold calculation, which blocks input.
   a_csr_blocks_input: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready ##1 !req_ready)
      else $error("input item accepted while the threshold is recalculated");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item presented straight after reset");

endmodule

bind bounded_random_rejection brr_checker u_brr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.bounded_value),
   .csr_we    (csr_we)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded random rejection testbench
// Drives entropy words through the mapper under a series of range settings,
// predicts the accepted values and rejections, and checks every bounded value
// in order. Both channels idle and stall at random except in full-rate phases.
// ----------------------------------------------------------------------------
module tb_top;

   typedef logic [brr_pkg::WORD_W-1:0] word_type;

   localparam int DRAIN_CYCLES  = 12;
   localparam int SETTLE_LIMIT  = 20000;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 45;

   // Holds the current range and the values still owed by the block.
   class bounded_value_board;
      word_type range_low;
      word_type range_high;
      word_type pending_values[$];
      int       failures;

      function new();
         range_low  = '0;
         range_high = '0;
         failures   = 0;
      endfunction

      function void write_reg(brr_pkg::csr_reg_type index, word_type data);
         case (index)
            brr_pkg::CSR_RANGE_LOW:  range_low  = data;
            brr_pkg::CSR_RANGE_HIGH: range_high = data;
            default: ;
         endcase
      endfunction

      // Returns 1 with the mapped value, or 0 when the word is rejected.
      function bit map_word(word_type word, output word_type value);
         word_type span;
         word_type low;
         word_type threshold;
         logic [2*brr_pkg::WORD_W-1:0] product;
         value = '0;
         if (range_low >= range_high) begin
            value = range_low;
            return 1'b1;
         end
         span      = range_high - range_low;
         product   = {{brr_pkg::WORD_W{1'b0}}, word} * {{brr_pkg::WORD_W{1'b0}}, span};
         low       = product[brr_pkg::WORD_W-1:0];
         threshold = (word_type'(0) - span) % span;
         if (low < threshold)
            return 1'b0;
         value = product[2*brr_pkg::WORD_W-1:brr_pkg::WORD_W] + range_low;
         return 1'b1;
      endfunction

      function void note_word(word_type word);
         word_type value;
         if (map_word(word, value))
            pending_values.push_back(value);
      endfunction

      function void check_value(word_type actual);
         word_type wanted;
         if (pending_values.size() == 0) begin
            $error("bounded_value: expected none, actual %h", actual);
            failures++;
            return;
         end
         wanted = pending_values.pop_front();
         if (actual !== wanted) begin
            $error("bounded_value: expected %h, actual %h", wanted, actual);
            failures++;
         end
      endfunction

      function void close_out();
         if (pending_values.size() != 0) begin
            $error("bounded_value: expected %h, actual none (%0d missing)",
                   pending_values[0], pending_values.size());
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [brr_pkg::CSR_IDX_W-1:0] csr_index;
   word_type csr_wdata;

   brr_req_if req_chan ();
   brr_rsp_if rsp_chan ();

   bounded_random_rejection i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bounded_value_board board = new();
   int idle_pct = 30;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb_top NOT OK");
      $finish;
   end

   // Observes every handshake and register write at the clock edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            board.write_reg(brr_pkg::csr_reg_type'(csr_index), csr_wdata);
         if (req_chan.valid && req_chan.ready)
            board.note_word(req_chan.entropy_word);
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_value(rsp_chan.bounded_value);
      end
   end

   // Result side: ready drops in random bursts.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            stall_left = $urandom_range(13, 0);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(word_type word);
      if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.entropy_word <= word;
      do
         @(posedge clock);
      while (!req_chan.ready);
   endtask

   // Lets every owed value arrive, then covers the pipeline in case the
   // last word was rejected and is still in flight. The first edge makes
   // sure the last accepted item has been noted on the board.
   task automatic settle();
      int waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_values.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_range(word_type lower, word_type upper);
      settle();
      csr_we    <= 1'b1;
      csr_index <= brr_pkg::CSR_RANGE_LOW;
      csr_wdata <= lower;
      @(posedge clock);
      csr_index <= brr_pkg::CSR_RANGE_HIGH;
      csr_wdata <= upper;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      word_type lower;
      word_type upper;
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= brr_pkg::CSR_RANGE_LOW;
      csr_wdata             <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.entropy_word <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset give an empty range: every word yields zero.
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);

      // A span of 2^31 + 1 rejects nearly half the words, word zero included.
      program_range(32'h0000_0010, 32'h8000_0011);
      send_word(32'h0000_0000);
      send_word(32'h0000_0001);
      send_word(32'h0000_0002);
      send_word(32'h7FFF_FFFF);
      send_word(32'h8000_0000);
      send_word(32'hFFFF_FFFF);

      // Widest span: only word zero is rejected.
      program_range(32'h0000_0000, 32'hFFFF_FFFF);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'h5555_5555);
      send_word(32'hAAAA_AAAA);

      // Equal bounds at the top, an inverted range and a span of one.
      program_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(32'h1234_5678);
      program_range(32'h0000_0007, 32'h0000_0003);
      send_word(32'hDEAD_BEEF);
      program_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_word(32'h0F0F_0F0F);
      send_word(32'hF0F0_F0F0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin lower = 32'd0;   upper = 32'd1;   end
            1: begin lower = 32'd100; upper = 32'd107; end
            2: begin lower = 32'd0;   upper = 32'h8000_0001; end
            3: begin lower = $urandom; upper = $urandom; end
            4: begin
               lower = $urandom_range(32'hFFFF_0000, 0);
               upper = lower + $urandom_range(1000, 2);
            end
            5: begin
               lower = $urandom | 32'h8000_0000;
               upper = lower - $urandom_range(32'h7FFF_FFFF, 1);
            end
            6: begin lower = 32'd0; upper = 32'hFFFF_FFFF; end
            7: begin lower = 32'hFFFF_FFFF; upper = 32'hFFFF_FFFF; end
            default: begin
               lower = $urandom_range(1000, 0);
               upper = lower + 32'h8000_0000 + $urandom_range(32'h1000_0000, 1);
            end
         endcase
         program_range(lower, upper);
         // Idle levels of 0, 25 and 60 percent take turns; the last phase runs at full rate.
         if (phase == RANDOM_PHASES - 1)
            idle_pct = 0;
         else
            idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 25 : 60);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_word($urandom);
      end

      settle();
      board.close_out();
      if (board.failures == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/brr_pkg.sv
hw/rtl/brr_if.sv
hw/rtl/bounded_random_rejection.sv
hw/rtl/brr_checker.sv
test/tb_top.sv
